[rtl/core/ucr_pkg.sv]
// ----------------------------------------------------------------------------
// ucr_pkg: shared types and constants of the control request responder
// Holds the beat layouts of both channels, the action and event codes, the
// standard request codes and the descriptor table.
// ----------------------------------------------------------------------------
package ucr_pkg;

  // Action code carried by every result beat.
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_ZLP   = 2'd2,
    ACT_STALL = 2'd3
  } act_t;

  // Event codes of an input beat.
  localparam logic [1:0] EVT_SETUP = 2'd0;
  localparam logic [1:0] EVT_ACK   = 2'd1;
  localparam logic [1:0] EVT_RESET = 2'd2;

  // Standard request codes.
  localparam logic [7:0] REQ_GET_STATUS     = 8'h00;
  localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'h01;
  localparam logic [7:0] REQ_SET_FEATURE    = 8'h03;
  localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
  localparam logic [7:0] REQ_GET_CONFIG     = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
  localparam logic [7:0] REQ_SET_INTERFACE  = 8'h0B;

  // Descriptor types.
  localparam logic [7:0] DT_DEVICE    = 8'h01;
  localparam logic [7:0] DT_CONFIG    = 8'h02;
  localparam logic [7:0] DT_STRING    = 8'h03;
  localparam logic [7:0] DT_QUALIFIER = 8'h06;

  // Descriptor table layout.
  localparam int unsigned ROM_SIZE = 71;
  localparam logic [6:0] OFS_DEVICE     = 7'd0;
  localparam logic [5:0] LEN_DEVICE     = 6'd18;
  localparam logic [6:0] OFS_CONFIG     = 7'd18;
  localparam logic [5:0] LEN_CONFIG     = 6'd32;
  localparam logic [6:0] OFS_LANG       = 7'd50;
  localparam logic [5:0] LEN_LANG       = 6'd4;
  localparam logic [6:0] OFS_STR1       = 7'd54;
  localparam logic [5:0] LEN_STR1       = 6'd7;
  localparam logic [6:0] OFS_STR2       = 7'd61;
  localparam logic [5:0] LEN_STR2       = 6'd6;
  localparam logic [6:0] OFS_STAT_DEV   = 7'd67;
  localparam logic [6:0] OFS_STAT_OTHER = 7'd69;
  localparam logic [5:0] LEN_STAT       = 6'd2;

  // Place of the max packet size byte in the device descriptor.
  localparam logic [7:0] MPS_BYTE_ADDR = 8'd7;

  // Descriptor table. The max packet size byte is patched at the read port.
  localparam logic [7:0] DESC_ROM [ROM_SIZE] = '{
    8'd18, 8'h01, 8'h00, 8'h20, 8'h02, 8'h00, 8'h00, 8'h08,
    8'h94, 8'h06, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h02, 8'h00, 8'h01,
    8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h00, 8'hC0, 8'h00,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'h00,
    8'h07, 8'h05, 8'h81, 8'h02, 8'h40, 8'h00, 8'h00,
    8'h07, 8'h05, 8'h02, 8'h02, 8'h40, 8'h00, 8'h00,
    8'h04, 8'h03, 8'h09, 8'h08,
    8'h07, 8'h03, 8'h4C, 8'h45, 8'h47, 8'h4F, 8'h00,
    8'h06, 8'h03, 8'h4E, 8'h58, 8'h54, 8'h00,
    8'h01, 8'h00, 8'h00, 8'h00
  };

  // One table byte; addresses past the end read as zero.
  function automatic logic [7:0] rom_byte(input logic [7:0] addr);
    logic [7:0] b;
    b = 8'h00;
    if (addr < 8'(ROM_SIZE)) begin
      b = DESC_ROM[addr[6:0]];
    end
    return b;
  endfunction

  // Input beat.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  request_type_bits;
    logic [7:0]  request_code;
    logic [15:0] value_word;
    logic [15:0] length_word;
  } ucr_in_t;

  // Result beat.
  typedef struct packed {
    act_t        action;
    logic [63:0] packet_data;
    logic [3:0]  packet_bytes;
    logic        direction_in;
    logic [6:0]  device_address;
    logic        address_enabled;
    logic        configured;
  } ucr_out_t;

endpackage

[rtl/core/ucr_in_if.sv]
// ----------------------------------------------------------------------------
// ucr_in_if: event channel of the control request responder
// Valid/ready channel that carries one decoded endpoint event per beat.
// ----------------------------------------------------------------------------
interface ucr_in_if import ucr_pkg::*; ();
  logic    valid;
  logic    ready;
  ucr_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/ucr_out_if.sv]
// ----------------------------------------------------------------------------
// ucr_out_if: result channel of the control request responder
// Valid/ready channel that carries one endpoint action per beat.
// ----------------------------------------------------------------------------
interface ucr_out_if import ucr_pkg::*; ();
  logic     valid;
  logic     ready;
  ucr_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/usb_control_request_responder_unit.sv]
// ----------------------------------------------------------------------------
// usb_control_request_responder_unit: endpoint-0 standard request responder
// Turns setup, acknowledge and bus reset events into endpoint-0 actions.
// ----------------------------------------------------------------------------
// The block takes one event beat per clock while the result side is not
// stalled, and returns exactly one result beat per event through the
// decision stage register and the output register. The rate of one beat per
// cycle is set by the request state update, which decides the action and
// advances the reply pointer in the cycle an event is accepted; the decision
// stage then reads the packet bytes out of the descriptor table into the
// output register. Long replies are continued one packet per acknowledge
// event, and a new address takes effect on the acknowledge after SET_ADDRESS.
module usb_control_request_responder_unit import ucr_pkg::*; #(
  parameter int unsigned EP0_PACKET_BYTES = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  ucr_in_if.sink    in_bus,
  ucr_out_if.source out_bus
);

  localparam logic [6:0] PKT_BYTES = 7'(EP0_PACKET_BYTES);

  // Reply lengths that end on a packet boundary, one bit per length.
  function automatic logic [63:0] boundary_mask();
    logic [63:0] m;
    m = '0;
    for (int k = 0; k < 64; k++) begin
      m[k] = ((k % EP0_PACKET_BYTES) == 0);
    end
    return m;
  endfunction

  localparam logic [63:0] LEN_ON_BOUNDARY = boundary_mask();

  // Request state.
  logic [7:0] cfg_r, cfg_nxt;
  logic [6:0] pos_r, pos_nxt;
  logic [6:0] rem_r, rem_nxt;
  logic       zlp_r, zlp_nxt;
  logic       apend_r, apend_nxt;
  logic [6:0] paddr_r, paddr_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic       addr_on_r, addr_on_nxt;

  // Decision stage toward the table read.
  logic       s1_v_r;
  act_t       s1_act_r, s1_act_nxt;
  logic [6:0] s1_pos_r, s1_pos_nxt;
  logic [3:0] s1_n_r, s1_n_nxt;
  logic       s1_getcfg_r, s1_getcfg_nxt;
  logic [7:0] s1_cfgval_r;
  logic       s1_dir_r, s1_dir_nxt;
  logic [6:0] s1_addr_r;
  logic       s1_addr_on_r;
  logic       s1_configured_r;

  // Output register.
  logic     out_v_r;
  ucr_out_t out_r, out_nxt;

  logic in_fire, out_adv, s1_move;

  // Beat flow between the two stages.
  assign out_adv      = !out_v_r || out_bus.ready;
  assign s1_move      = s1_v_r && out_adv;
  assign in_bus.ready = !s1_v_r || out_adv;
  assign in_fire      = in_bus.valid && in_bus.ready;

  // Event decode and state update.
  always_comb begin
    logic       start;
    logic       do_emit;
    logic [6:0] ofs;
    logic [5:0] len;
    logic [5:0] lenc;
    logic [6:0] pos_base;
    logic [6:0] rem_base;
    logic [3:0] n;
    ucr_in_t    ev;

    ev            = in_bus.data;
    start         = 1'b0;
    do_emit       = 1'b0;
    ofs           = '0;
    len           = '0;
    lenc          = '0;
    pos_base      = pos_r;
    rem_base      = rem_r;
    n             = '0;
    cfg_nxt       = cfg_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    zlp_nxt       = zlp_r;
    apend_nxt     = apend_r;
    paddr_nxt     = paddr_r;
    addr_nxt      = addr_r;
    addr_on_nxt   = addr_on_r;
    s1_act_nxt    = ACT_NONE;
    s1_pos_nxt    = '0;
    s1_n_nxt      = '0;
    s1_getcfg_nxt = 1'b0;
    s1_dir_nxt    = 1'b0;

    case (ev.req_type)
      EVT_SETUP: begin
        s1_dir_nxt = ev.request_type_bits[7];
        pos_nxt    = '0;
        rem_nxt    = '0;
        zlp_nxt    = 1'b0;
        apend_nxt  = 1'b0;
        paddr_nxt  = '0;
        case (ev.request_code)
          REQ_GET_STATUS: begin
            start = 1'b1;
            len   = LEN_STAT;
            ofs   = (ev.request_type_bits[3:0] == 4'd0) ? OFS_STAT_DEV : OFS_STAT_OTHER;
          end
          REQ_CLEAR_FEATURE, REQ_SET_FEATURE, REQ_SET_INTERFACE: begin
            s1_act_nxt = ACT_ZLP;
          end
          REQ_SET_ADDRESS: begin
            apend_nxt  = 1'b1;
            paddr_nxt  = ev.value_word[6:0];
            s1_act_nxt = ACT_ZLP;
          end
          REQ_GET_DESCRIPTOR: begin
            s1_act_nxt = ACT_STALL;
            if (ev.value_word[15:8] == DT_DEVICE) begin
              start = 1'b1;
              ofs   = OFS_DEVICE;
              len   = LEN_DEVICE;
            end else if (ev.value_word[15:8] == DT_CONFIG) begin
              start = 1'b1;
              ofs   = OFS_CONFIG;
              len   = LEN_CONFIG;
            end else if (ev.value_word[15:8] == DT_STRING) begin
              if (ev.value_word[7:0] == 8'd0) begin
                start = 1'b1;
                ofs   = OFS_LANG;
                len   = LEN_LANG;
              end else if (ev.value_word[7:0] == 8'd1) begin
                start = 1'b1;
                ofs   = OFS_STR1;
                len   = LEN_STR1;
              end else if (ev.value_word[7:0] == 8'd2) begin
                start = 1'b1;
                ofs   = OFS_STR2;
                len   = LEN_STR2;
              end
            end else if (ev.value_word[15:8] == DT_QUALIFIER) begin
              s1_act_nxt = ACT_ZLP;
            end
          end
          REQ_GET_CONFIG: begin
            if (ev.length_word == 16'd0) begin
              s1_act_nxt = ACT_ZLP;
            end else begin
              s1_act_nxt    = ACT_DATA;
              s1_getcfg_nxt = 1'b1;
              s1_n_nxt      = 4'd1;
            end
          end
          REQ_SET_CONFIG: begin
            cfg_nxt    = ev.value_word[7:0];
            s1_act_nxt = ACT_ZLP;
          end
          default: begin
            s1_act_nxt = ACT_STALL;
          end
        endcase

        // Reply start: cut to the host's length, then send the first packet.
        if (start) begin
          lenc = (ev.length_word < 16'(len)) ? ev.length_word[5:0] : len;
          if (lenc == 6'd0) begin
            s1_act_nxt = ACT_ZLP;
          end else begin
            pos_base = ofs;
            rem_base = 7'(lenc);
            zlp_nxt  = (16'(lenc) < ev.length_word) && LEN_ON_BOUNDARY[lenc];
            do_emit  = 1'b1;
          end
        end
      end
      EVT_ACK: begin
        if (rem_r != 7'd0) begin
          do_emit = 1'b1;
        end else if (zlp_r) begin
          zlp_nxt    = 1'b0;
          s1_act_nxt = ACT_ZLP;
        end else if (apend_r) begin
          addr_nxt    = paddr_r;
          addr_on_nxt = (paddr_r != 7'd0);
          apend_nxt   = 1'b0;
          paddr_nxt   = '0;
        end
      end
      EVT_RESET: begin
        cfg_nxt     = '0;
        pos_nxt     = '0;
        rem_nxt     = '0;
        zlp_nxt     = 1'b0;
        apend_nxt   = 1'b0;
        paddr_nxt   = '0;
        addr_nxt    = '0;
        addr_on_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    // Next packet of the reply: advance the table pointer.
    if (do_emit) begin
      n          = (rem_base < PKT_BYTES) ? rem_base[3:0] : PKT_BYTES[3:0];
      pos_nxt    = pos_base + 7'(n);
      rem_nxt    = rem_base - 7'(n);
      s1_act_nxt = ACT_DATA;
      s1_pos_nxt = pos_base;
      s1_n_nxt   = n;
    end
  end

  // Request state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= '0;
      pos_r     <= '0;
      rem_r     <= '0;
      zlp_r     <= 1'b0;
      apend_r   <= 1'b0;
      paddr_r   <= '0;
      addr_r    <= '0;
      addr_on_r <= 1'b0;
    end else if (in_fire) begin
      cfg_r     <= cfg_nxt;
      pos_r     <= pos_nxt;
      rem_r     <= rem_nxt;
      zlp_r     <= zlp_nxt;
      apend_r   <= apend_nxt;
      paddr_r   <= paddr_nxt;
      addr_r    <= addr_nxt;
      addr_on_r <= addr_on_nxt;
    end
  end

  // Decision stage: valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  // Decision stage: payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_act_r        <= s1_act_nxt;
      s1_pos_r        <= s1_pos_nxt;
      s1_n_r          <= s1_n_nxt;
      s1_getcfg_r     <= s1_getcfg_nxt;
      s1_cfgval_r     <= cfg_r;
      s1_dir_r        <= s1_dir_nxt;
      s1_addr_r       <= addr_nxt;
      s1_addr_on_r    <= addr_on_nxt;
      s1_configured_r <= (cfg_nxt != 8'd0);
    end
  end

  // Table read: gather up to eight bytes starting at the reply pointer.
  always_comb begin
    logic [63:0] window;
    logic [7:0]  a;
    logic [7:0]  b;
    window = '0;
    for (int i = 0; i < 8; i++) begin
      a = 8'(s1_pos_r) + 8'(i);
      b = (a == MPS_BYTE_ADDR) ? 8'(EP0_PACKET_BYTES) : rom_byte(a);
      if (4'(i) < s1_n_r) begin
        window[8*i +: 8] = b;
      end
    end
    out_nxt.action          = s1_act_r;
    out_nxt.packet_data     = s1_getcfg_r ? {56'd0, s1_cfgval_r} : window;
    out_nxt.packet_bytes    = s1_n_r;
    out_nxt.direction_in    = s1_dir_r;
    out_nxt.device_address  = s1_addr_r;
    out_nxt.address_enabled = s1_addr_on_r;
    out_nxt.configured      = s1_configured_r;
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= s1_v_r;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_r <= out_nxt;
    end
  end

  assign out_bus.valid = out_v_r;
  assign out_bus.data  = out_r;

  // Only a data beat carries bytes.
  a_bytes_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_r.action != ACT_DATA) |-> (out_r.packet_bytes == 4'd0))
    else $error("non-data beat carries packet bytes");

  // A data beat never exceeds the packet size.
  a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (32'(out_r.packet_bytes) <= EP0_PACKET_BYTES))
    else $error("packet longer than the endpoint packet size");

  // The address is enabled only with a nonzero address in effect.
  a_addr_enable: assert property (@(posedge clk) disable iff (!rst_n)
    addr_on_r |-> (addr_r != 7'd0))
    else $error("address enabled with address zero");

  // A bus reset clears the reply, the address and the configuration.
  a_bus_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_bus.data.req_type == EVT_RESET) |=>
      (rem_r == 7'd0) && !zlp_r && !addr_on_r && (cfg_r == 8'd0))
    else $error("bus reset left state behind");

  // An empty decision stage always takes the next event.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_bus.ready)
    else $error("input stalled with an empty pipeline");

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: endpoint-0 standard request responder
// Drives setup, acknowledge, bus reset and unused event beats into the block.
// A predictor holds its own copy of the responder state and the descriptor
// table, and every result beat is checked field by field against it.
// Directed requests come first, then random control transfers under three
// idle patterns, then a long hold-off on the result side.
// ----------------------------------------------------------------------------
module testbench;
  import ucr_pkg::*;

  localparam int unsigned PKT_BYTES   = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 10;

  // Event code that the block must ignore.
  localparam logic [1:0] EVT_UNUSED = 2'd3;

  // Recipient field of bmRequestType.
  localparam logic [3:0] RECIP_DEVICE    = 4'd0;
  localparam logic [3:0] RECIP_INTERFACE = 4'd1;
  localparam logic [3:0] RECIP_ENDPOINT  = 4'd2;

  // Direction bit of bmRequestType.
  localparam logic [7:0] DIR_TO_HOST = 8'h80;

  // String descriptor indexes.
  localparam logic [7:0] STR_LANGUAGES = 8'd0;
  localparam logic [7:0] STR_FIRST     = 8'd1;
  localparam logic [7:0] STR_SECOND    = 8'd2;

  // Request codes with no handler in the block.
  localparam logic [7:0] REQ_GET_INTERFACE = 8'h0A;
  localparam logic [7:0] REQ_UNDEFINED     = 8'hFF;

  // Layout of the descriptor table.
  localparam int unsigned TABLE_LEN    = 71;
  localparam logic [6:0]  DEV_AT       = 7'd0;
  localparam int unsigned DEV_LEN      = 18;
  localparam logic [6:0]  CONF_AT      = 7'd18;
  localparam int unsigned CONF_LEN     = 32;
  localparam logic [6:0]  LANG_AT      = 7'd50;
  localparam int unsigned LANG_LEN     = 4;
  localparam logic [6:0]  STR1_AT      = 7'd54;
  localparam int unsigned STR1_LEN     = 7;
  localparam logic [6:0]  STR2_AT      = 7'd61;
  localparam int unsigned STR2_LEN     = 6;
  localparam logic [6:0]  STAT_DEV_AT  = 7'd67;
  localparam logic [6:0]  STAT_OTH_AT  = 7'd69;
  localparam int unsigned STAT_LEN     = 2;

  logic clk = 1'b0;
  logic rst_n;

  ucr_in_if  in_if ();
  ucr_out_if out_if ();

  usb_control_request_responder_unit #(
    .EP0_PACKET_BYTES(PKT_BYTES)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_if),
    .out_bus(out_if)
  );

  // Clock with an 8 ns period.
  always #4 clk = ~clk;

  // Descriptor table as the host should see it.
  logic [7:0] desc_bytes [0:TABLE_LEN-1] = '{
    8'd18, 8'h01, 8'h00, 8'h20, 8'h02, 8'h00, 8'h00, 8'(PKT_BYTES),
    8'h94, 8'h06, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h02, 8'h00, 8'h01,
    8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h00, 8'hC0, 8'h00,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'h00,
    8'h07, 8'h05, 8'h81, 8'h02, 8'h40, 8'h00, 8'h00,
    8'h07, 8'h05, 8'h02, 8'h02, 8'h40, 8'h00, 8'h00,
    8'h04, 8'h03, 8'h09, 8'h08,
    8'h07, 8'h03, 8'h4C, 8'h45, 8'h47, 8'h4F, 8'h00,
    8'h06, 8'h03, 8'h4E, 8'h58, 8'h54, 8'h00,
    8'h01, 8'h00, 8'h00, 8'h00
  };

  // wLength values that sit on reply sizes and packet boundaries.
  logic [15:0] boundary_lengths [0:8] = '{
    16'd2, 16'd4, 16'd6, 16'd7, 16'd8, 16'd16, 16'd18, 16'd24, 16'd32
  };

  // Responder state as predicted.
  logic [7:0] cfg_value  = '0;
  logic [6:0] rd_pos     = '0;
  logic [6:0] left_bytes = '0;
  logic       zlp_due    = 1'b0;
  logic       addr_due   = 1'b0;
  logic [6:0] addr_next  = '0;
  logic [6:0] addr_now   = '0;
  logic       addr_live  = 1'b0;

  ucr_out_t expected_results [$];

  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_idle_pct  = 0;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Bus reset puts every register back to zero, the address included.
  function automatic void clear_state();
    cfg_value  = '0;
    rd_pos     = '0;
    left_bytes = '0;
    zlp_due    = 1'b0;
    addr_due   = 1'b0;
    addr_next  = '0;
    addr_now   = '0;
    addr_live  = 1'b0;
  endfunction

  // Next packet of the reply in progress; bytes past the table read as zero.
  function automatic ucr_out_t next_packet();
    ucr_out_t r;
    int unsigned n;
    logic [7:0] a;
    r = '0;
    n = PKT_BYTES;
    if (n > left_bytes) n = left_bytes;
    for (int i = 0; i < n; i++) begin
      a = {1'b0, rd_pos} + 8'(i);
      r.packet_data[8*i +: 8] = (a < TABLE_LEN) ? desc_bytes[a[6:0]] : 8'h00;
    end
    rd_pos       = rd_pos + 7'(n);
    left_bytes   = left_bytes - 7'(n);
    r.action     = ACT_DATA;
    r.packet_bytes = 4'(n);
    return r;
  endfunction

  // Opens a reply cut to wLength. A reply that ends short of wLength on a
  // packet boundary is closed later by a zero-length packet.
  function automatic ucr_out_t open_reply(logic [6:0] at, int unsigned full_len,
                                          logic [15:0] wlen);
    ucr_out_t r;
    int unsigned len;
    r = '0;
    len = full_len;
    if (len > wlen) len = 32'(wlen);
    if (len == 0) begin
      r.action = ACT_ZLP;
      return r;
    end
    rd_pos     = at;
    left_bytes = 7'(len);
    zlp_due    = (len < wlen) && ((len % PKT_BYTES) == 0);
    return next_packet();
  endfunction

  // Setup beat: any earlier reply and pending address are dropped first.
  function automatic ucr_out_t answer_setup(ucr_in_t b);
    ucr_out_t r;
    logic [7:0] dtype;
    logic [7:0] idx;
    r = '0;
    dtype = b.value_word[15:8];
    idx   = b.value_word[7:0];
    rd_pos     = '0;
    left_bytes = '0;
    zlp_due    = 1'b0;
    addr_due   = 1'b0;
    addr_next  = '0;
    r.action   = ACT_STALL;
    case (b.request_code)
      REQ_GET_STATUS: begin
        if (b.request_type_bits[3:0] == RECIP_DEVICE) begin
          r = open_reply(STAT_DEV_AT, STAT_LEN, b.length_word);
        end else begin
          r = open_reply(STAT_OTH_AT, STAT_LEN, b.length_word);
        end
      end
      REQ_CLEAR_FEATURE, REQ_SET_FEATURE, REQ_SET_INTERFACE: begin
        r.action = ACT_ZLP;
      end
      REQ_SET_ADDRESS: begin
        addr_due  = 1'b1;
        addr_next = b.value_word[6:0];
        r.action  = ACT_ZLP;
      end
      REQ_GET_DESCRIPTOR: begin
        if (dtype == DT_DEVICE) begin
          r = open_reply(DEV_AT, DEV_LEN, b.length_word);
        end else if (dtype == DT_CONFIG) begin
          r = open_reply(CONF_AT, CONF_LEN, b.length_word);
        end else if (dtype == DT_STRING) begin
          if (idx == STR_LANGUAGES) begin
            r = open_reply(LANG_AT, LANG_LEN, b.length_word);
          end else if (idx == STR_FIRST) begin
            r = open_reply(STR1_AT, STR1_LEN, b.length_word);
          end else if (idx == STR_SECOND) begin
            r = open_reply(STR2_AT, STR2_LEN, b.length_word);
          end
        end else if (dtype == DT_QUALIFIER) begin
          r.action = ACT_ZLP;
        end
      end
      REQ_GET_CONFIG: begin
        if (b.length_word == 16'd0) begin
          r.action = ACT_ZLP;
        end else begin
          r.action           = ACT_DATA;
          r.packet_data[7:0] = cfg_value;
          r.packet_bytes     = 4'd1;
        end
      end
      REQ_SET_CONFIG: begin
        cfg_value = b.value_word[7:0];
        r.action  = ACT_ZLP;
      end
      default: r.action = ACT_STALL;
    endcase
    return r;
  endfunction

  // Acknowledge: continue the reply, then close it, then apply the address.
  function automatic ucr_out_t answer_ack();
    ucr_out_t r;
    r = '0;
    if (left_bytes != 0) return next_packet();
    if (zlp_due) begin
      zlp_due  = 1'b0;
      r.action = ACT_ZLP;
      return r;
    end
    if (addr_due) begin
      addr_now  = addr_next;
      addr_live = (addr_next != 0);
      addr_due  = 1'b0;
      addr_next = '0;
    end
    r.action = ACT_NONE;
    return r;
  endfunction

  // Expected result beat of one accepted event beat.
  function automatic ucr_out_t predict_result(ucr_in_t b);
    ucr_out_t r;
    r = '0;
    case (b.req_type)
      EVT_SETUP: begin
        r = answer_setup(b);
        r.direction_in = b.request_type_bits[7];
      end
      EVT_ACK:   r = answer_ack();
      EVT_RESET: clear_state();
      default:   r = '0;
    endcase
    if (r.action != ACT_DATA) begin
      r.packet_data  = '0;
      r.packet_bytes = '0;
    end
    r.device_address  = addr_now;
    r.address_enabled = addr_live;
    r.configured      = (cfg_value != 0);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitors and checker
  // --------------------------------------------------------------------------

  // Each event beat accepted by the block gets its prediction queued.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      expected_results.push_back(predict_result(in_if.data));
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Each result beat is compared with the oldest prediction.
  always @(posedge clk) begin
    ucr_out_t want;
    ucr_out_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_results.size() == 0) begin
        $error("result beat with no prediction waiting, action %0d", got.action);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("action", 64'(want.action), 64'(got.action));
        check_field("packet_data", want.packet_data, got.packet_data);
        check_field("packet_bytes", 64'(want.packet_bytes), 64'(got.packet_bytes));
        check_field("direction_in", 64'(want.direction_in), 64'(got.direction_in));
        check_field("device_address", 64'(want.device_address),
                    64'(got.device_address));
        check_field("address_enabled", 64'(want.address_enabled),
                    64'(got.address_enabled));
        check_field("configured", 64'(want.configured), 64'(got.configured));
      end
    end
  end

  // Result side ready, with random stalls and requested long hold-offs.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Offers one event beat after random idle cycles and waits for acceptance.
  task automatic send_beat(ucr_in_t b);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= b;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic send_setup(logic [7:0] rtype, logic [7:0] code, logic [15:0] value,
                            logic [15:0] wlen);
    ucr_in_t b;
    b.req_type          = EVT_SETUP;
    b.request_type_bits = rtype;
    b.request_code      = code;
    b.value_word        = value;
    b.length_word       = wlen;
    send_beat(b);
  endtask

  task automatic send_event(logic [1:0] kind);
    ucr_in_t b;
    b.req_type          = kind;
    b.request_type_bits = 8'($urandom_range(255));
    b.request_code      = 8'($urandom_range(255));
    b.value_word        = 16'($urandom_range(16'hFFFF));
    b.length_word       = 16'($urandom_range(16'hFFFF));
    send_beat(b);
  endtask

  function automatic logic [15:0] random_length();
    logic [15:0] len;
    case ($urandom_range(5))
      0:       len = 16'd0;
      1:       len = 16'($urandom_range(1, 9));
      2:       len = boundary_lengths[4'($urandom_range(8))];
      3:       len = 16'($urandom_range(10, 80));
      4:       len = 16'hFFFF;
      default: len = 16'($urandom_range(16'hFFFF));
    endcase
    return len;
  endfunction

  // Setup beat weighted toward the requests the block answers.
  function automatic ucr_in_t random_setup();
    ucr_in_t b;
    int unsigned pick;
    logic [7:0] dtype;
    pick = $urandom_range(19);
    b.req_type          = EVT_SETUP;
    b.request_type_bits = 8'($urandom_range(255));
    if ($urandom_range(1) == 0) b.request_type_bits[3:0] = RECIP_DEVICE;
    b.value_word  = 16'($urandom_range(16'hFFFF));
    b.length_word = random_length();
    if (pick < 6) begin
      b.request_code = REQ_GET_DESCRIPTOR;
    end else if (pick < 18) begin
      case ($urandom_range(7))
        0:       b.request_code = REQ_GET_STATUS;
        1:       b.request_code = REQ_CLEAR_FEATURE;
        2:       b.request_code = REQ_SET_FEATURE;
        3:       b.request_code = REQ_SET_ADDRESS;
        4:       b.request_code = REQ_GET_CONFIG;
        5:       b.request_code = REQ_SET_CONFIG;
        6:       b.request_code = REQ_SET_INTERFACE;
        default: b.request_code = REQ_GET_DESCRIPTOR;
      endcase
    end else begin
      b.request_code = 8'($urandom_range(255));
    end
    // Mostly well-formed descriptor selectors, sometimes anything.
    if (b.request_code == REQ_GET_DESCRIPTOR && $urandom_range(4) != 0) begin
      case ($urandom_range(4))
        0:       dtype = DT_DEVICE;
        1:       dtype = DT_CONFIG;
        2:       dtype = DT_QUALIFIER;
        default: dtype = DT_STRING;
      endcase
      b.value_word = {dtype, 8'($urandom_range(3))};
    end
    if ((b.request_code == REQ_SET_ADDRESS || b.request_code == REQ_SET_CONFIG) &&
        $urandom_range(5) == 0) begin
      b.value_word = '0;
    end
    return b;
  endfunction

  // Status, feature and unknown requests, and the unused event code.
  task automatic test_status_and_features();
    send_setup(DIR_TO_HOST | 8'(RECIP_DEVICE), REQ_GET_STATUS, 16'h0000, 16'd2);
    send_setup(DIR_TO_HOST | 8'(RECIP_INTERFACE), REQ_GET_STATUS, 16'hFFFF, 16'hFFFF);
    send_setup(8'(RECIP_ENDPOINT), REQ_GET_STATUS, 16'h0000, 16'd1);
    send_setup(8'h00, REQ_CLEAR_FEATURE, 16'h0001, 16'd0);
    send_setup(8'h01, REQ_SET_INTERFACE, 16'h0000, 16'd0);
    send_setup(DIR_TO_HOST, REQ_GET_INTERFACE, 16'h0000, 16'd1);
    send_setup(8'hFF, REQ_UNDEFINED, 16'hFFFF, 16'hFFFF);
    send_event(EVT_UNUSED);
  endtask

  // Descriptor replies: cut short, multi-packet with a closing zero-length
  // packet, strings, unknown string index, qualifier, unknown type, wLength 0.
  task automatic test_descriptor_replies();
    send_setup(DIR_TO_HOST, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'd10);
    send_event(EVT_ACK);
    send_setup(DIR_TO_HOST, REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 16'hFFFF);
    repeat (4) send_event(EVT_ACK);
    send_event(EVT_ACK);
    send_setup(DIR_TO_HOST, REQ_GET_DESCRIPTOR, {DT_STRING, STR_FIRST}, 16'hFFFF);
    send_setup(DIR_TO_HOST, REQ_GET_DESCRIPTOR, {DT_STRING, 8'd3}, 16'd64);
    send_setup(DIR_TO_HOST, REQ_GET_DESCRIPTOR, {DT_QUALIFIER, 8'h00}, 16'd10);
    send_setup(DIR_TO_HOST, REQ_GET_DESCRIPTOR, {8'hFF, 8'hFF}, 16'd64);
    send_setup(DIR_TO_HOST, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'd0);
  endtask

  // Configuration value, address applied on the next acknowledge, bus reset.
  task automatic test_config_and_address();
    send_setup(8'h00, REQ_SET_CONFIG, 16'h00FF, 16'd0);
    send_setup(DIR_TO_HOST, REQ_GET_CONFIG, 16'h0000, 16'd1);
    send_setup(8'h00, REQ_SET_ADDRESS, 16'h007F, 16'd0);
    send_event(EVT_ACK);
    send_event(EVT_RESET);
  endtask

  // Random control transfers: a setup and some acknowledges, with noise.
  task automatic test_random_traffic(int unsigned beats, int unsigned snd_pct,
                                     int unsigned rcv_pct);
    int unsigned sent;
    int unsigned acks;
    ucr_in_t b;
    sent = 0;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    while (sent < beats) begin
      if ($urandom_range(99) < 75) begin
        send_beat(random_setup());
        acks = $urandom_range(6);
        repeat (acks) send_event(EVT_ACK);
        sent += acks + 1;
      end else begin
        b = random_setup();
        b.req_type = 2'($urandom_range(3));
        send_beat(b);
        if (b.req_type != EVT_UNUSED) sent++;
      end
    end
  endtask

  // Long hold-off on the result side while beats keep being offered.
  task automatic test_output_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_request = 200;
    send_setup(DIR_TO_HOST, REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 16'hFFFF);
    repeat (5) send_event(EVT_ACK);
    repeat (30) send_beat(random_setup());
  endtask

  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 23;
    rcv_idle_pct = 67;
    test_status_and_features();
    test_descriptor_replies();
    test_config_and_address();

    test_random_traffic(500, 23, 67);
    test_random_traffic(500, 67, 23);
    test_random_traffic(500, 0, 0);
    test_output_backpressure();
    in_if.valid <= 1'b0;

    // Let the remaining results drain, then wait on for DRAIN_WAIT.
    rcv_idle_pct = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
